// ===== src/cfsb_pkg.sv =====
// Shared types, constants and helpers for the clipped, flipped sprite blit.
package cfsb_pkg;

  localparam int unsigned ScreenWidth = 320;
  localparam int unsigned CoordBits   = 10;
  localparam int unsigned EdgeW       = 20;
  localparam int unsigned AddrW       = 16;
  localparam int unsigned ExtW        = 10;

  typedef enum logic {
    KindStart = 1'b0,
    KindPixel = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    RegClipLeft   = 2'd0,
    RegClipTop    = 2'd1,
    RegClipRight  = 2'd2,
    RegClipBottom = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [8:0] clip_left;
    logic [7:0] clip_top;
    logic [8:0] clip_right;
    logic [7:0] clip_bottom;
  } cfg_t;

  // one queue entry: a resolved start or a pixel byte
  typedef struct packed {
    kind_e                kind;
    logic                 ok;
    logic [CoordBits-1:0] row_start;
    logic [CoordBits-1:0] col_start;
    logic [CoordBits:0]   row_lim;
    logic [CoordBits:0]   col_lim;
    logic [ExtW-1:0]      stride;
    logic [AddrW-1:0]     addr;
    logic                 mirror_x;
    logic                 mirror_y;
    logic [7:0]           pixel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic signed [EdgeW-1:0] sx16(input logic [15:0] x);
    return EdgeW'($signed(x));
  endfunction

  function automatic logic signed [EdgeW-1:0] zx(input logic [ExtW-1:0] x);
    return $signed(EdgeW'(x));
  endfunction

endpackage

// ===== src/cfsb_if.sv =====
// Item channels: sprite/pixel input and framebuffer write output.
interface cfsb_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [9:0]  extent_w;
  logic [9:0]  extent_h;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic signed [15:0] offset_x_reloaded;
  logic [9:0]  row_stride;
  logic        mirror_x;
  logic        mirror_y;
  logic [7:0]  pixel;

  modport source (
    output valid, kind, pos_x, pos_y, extent_w, extent_h, offset_x, offset_y,
           offset_x_reloaded, row_stride, mirror_x, mirror_y, pixel,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, extent_w, extent_h, offset_x, offset_y,
           offset_x_reloaded, row_stride, mirror_x, mirror_y, pixel,
    output ready
  );
endinterface

interface cfsb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] write_address;
  logic [7:0]  write_pixel;
  logic        last;

  modport source (output valid, write_address, write_pixel, last, input ready);
  modport sink (input valid, write_address, write_pixel, last, output ready);
endinterface

// ===== src/cfsb_front.sv =====
// Front pipeline: edge sums, clipping, window selection and start address.
module cfsb_front import cfsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  cfsb_in_if.sink     in_i,
  input  logic        q_full_i,
  output logic        push_o,
  output cmd_t        push_data_o
);

  typedef struct packed {
    kind_e                   kind;
    logic signed [EdgeW-1:0] top;
    logic signed [EdgeW-1:0] bottom;
    logic signed [EdgeW-1:0] left;
    logic signed [EdgeW-1:0] right;
    logic [ExtW-1:0]         eh;
    logic [ExtW-1:0]         ew;
    logic [ExtW-1:0]         stride;
    logic                    fx;
    logic                    fy;
    logic [7:0]              pixel;
  } s1_t;

  typedef struct packed {
    kind_e                   kind;
    logic signed [EdgeW-1:0] h;
    logic signed [EdgeW-1:0] w;
    logic signed [EdgeW-1:0] rs;
    logic signed [EdgeW-1:0] cs;
    logic [AddrW-1:0]        dy;
    logic [AddrW-1:0]        dx;
    logic [ExtW-1:0]         stride;
    logic                    fx;
    logic                    fy;
    logic [7:0]              pixel;
  } s2_t;

  typedef struct packed {
    kind_e                kind;
    logic                 ok;
    logic [CoordBits-1:0] rs;
    logic [CoordBits-1:0] cs;
    logic [CoordBits-1:0] rows;
    logic [CoordBits-1:0] cols;
    logic [AddrW-1:0]     dy;
    logic [AddrW-1:0]     dx;
    logic [ExtW-1:0]      stride;
    logic                 fx;
    logic                 fy;
    logic [7:0]           pixel;
  } s3_t;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;

  assign en3 = !v3_q || !q_full_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;
  assign push_o = v3_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
  end

  // edges in exact arithmetic
  always_comb begin
    s1_d.kind   = kind_e'(in_i.kind);
    s1_d.top    = sx16(in_i.pos_y) + sx16(in_i.offset_y);
    s1_d.bottom = sx16(in_i.pos_y) + zx(in_i.extent_h) + sx16(in_i.offset_y);
    s1_d.left   = sx16(in_i.pos_x) + sx16(in_i.offset_x_reloaded);
    s1_d.right  = sx16(in_i.pos_x) + zx(in_i.extent_w) + sx16(in_i.offset_x);
    s1_d.eh     = in_i.extent_h;
    s1_d.ew     = in_i.extent_w;
    s1_d.stride = in_i.row_stride;
    s1_d.fx     = in_i.mirror_x;
    s1_d.fy     = in_i.mirror_y;
    s1_d.pixel  = in_i.pixel;
  end

  // clip amounts against the dirty rectangle
  logic signed [EdgeW-1:0] ct_s, cb_s, cl_s, cr_s;
  logic signed [EdgeW-1:0] c_t, c_b, c_l, c_r;
  logic t_lt, b_ge, l_lt, r_ge;

  always_comb begin
    ct_s = $signed(EdgeW'(cfg_i.clip_top));
    cb_s = $signed(EdgeW'(cfg_i.clip_bottom));
    cl_s = $signed(EdgeW'(cfg_i.clip_left));
    cr_s = $signed(EdgeW'(cfg_i.clip_right));
    t_lt = s1_q.top < ct_s;
    b_ge = s1_q.bottom >= cb_s;
    l_lt = s1_q.left < cl_s;
    r_ge = s1_q.right >= cr_s;
    c_t  = t_lt ? ct_s - s1_q.top : '0;
    c_b  = b_ge ? s1_q.bottom - cb_s : '0;
    c_l  = l_lt ? cl_s - s1_q.left : '0;
    c_r  = r_ge ? s1_q.right - cr_s : '0;

    s2_d.kind   = s1_q.kind;
    s2_d.h      = zx(s1_q.eh) - c_t - c_b;
    s2_d.w      = zx(s1_q.ew) - c_l - c_r;
    s2_d.rs     = s1_q.fy ? c_b : c_t;
    s2_d.cs     = s1_q.fx ? c_r : c_l;
    s2_d.dy     = t_lt ? AddrW'(cfg_i.clip_top) : s1_q.top[AddrW-1:0];
    s2_d.dx     = l_lt ? AddrW'(cfg_i.clip_left) : s1_q.left[AddrW-1:0];
    s2_d.stride = s1_q.stride;
    s2_d.fx     = s1_q.fx;
    s2_d.fy     = s1_q.fy;
    s2_d.pixel  = s1_q.pixel;
  end

  // window cut to the stride, far corner for mirrored axes
  logic signed [EdgeW-1:0] stride_s, cs_end, cols_s;

  always_comb begin
    stride_s = zx(s2_q.stride);
    cs_end   = s2_q.cs + s2_q.w;
    cols_s   = (cs_end > stride_s) ? stride_s - s2_q.cs : s2_q.w;

    s3_d.kind   = s2_q.kind;
    s3_d.ok     = (s2_q.h > 0) && (s2_q.w > 0) && (s2_q.cs < stride_s);
    s3_d.rs     = s2_q.rs[CoordBits-1:0];
    s3_d.cs     = s2_q.cs[CoordBits-1:0];
    s3_d.rows   = s2_q.h[CoordBits-1:0];
    s3_d.cols   = cols_s[CoordBits-1:0];
    s3_d.dy     = s2_q.fy ? s2_q.dy + s2_q.h[AddrW-1:0] - AddrW'(1) : s2_q.dy;
    s3_d.dx     = s2_q.fx ? s2_q.dx + s2_q.w[AddrW-1:0] - AddrW'(1) : s2_q.dx;
    s3_d.stride = s2_q.stride;
    s3_d.fx     = s2_q.fx;
    s3_d.fy     = s2_q.fy;
    s3_d.pixel  = s2_q.pixel;
  end

  // start address: row times screen width plus column, wrapping
  logic [2*AddrW-1:0] row_prod;

  always_comb begin
    row_prod = (2*AddrW)'(s3_q.dy) * (2*AddrW)'(ScreenWidth);
    push_data_o.kind      = s3_q.kind;
    push_data_o.ok        = s3_q.ok;
    push_data_o.row_start = s3_q.rs;
    push_data_o.col_start = s3_q.cs;
    push_data_o.row_lim   = (CoordBits+1)'(s3_q.rs) + (CoordBits+1)'(s3_q.rows);
    push_data_o.col_lim   = (CoordBits+1)'(s3_q.cs) + (CoordBits+1)'(s3_q.cols);
    push_data_o.stride    = s3_q.stride;
    push_data_o.addr      = row_prod[AddrW-1:0] + s3_q.dx;
    push_data_o.mirror_x  = s3_q.fx;
    push_data_o.mirror_y  = s3_q.fy;
    push_data_o.pixel     = s3_q.pixel;
  end

endmodule

// ===== src/cfsb_queue.sv =====
// Small FIFO of resolved items between front and back.
module cfsb_queue import cfsb_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_data_i,
  input  logic    pop_i,
  output cmd_t    pop_data_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== src/cfsb_back.sv =====
// Back end: window cursor, address stepping and output register.
module cfsb_back import cfsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  cfsb_out_if.source  out_o
);

  logic                 busy_q, busy_d;
  logic [CoordBits-1:0] row_start_q, col_start_q;
  logic [CoordBits:0]   row_lim_q, col_lim_q;
  logic [ExtW-1:0]      stride_q;
  logic [CoordBits-1:0] src_row_q, src_row_d, src_col_q, src_col_d;
  logic [AddrW-1:0]     row_base_q, row_base_d, col_addr_q, col_addr_d;
  logic                 mx_q, my_q;

  logic                 out_valid_q, out_valid_d;
  logic [AddrW-1:0]     out_addr_q;
  logic [7:0]           out_pixel_q;
  logic                 out_last_q;

  logic                 in_win, row_done, fin, emit;
  logic [CoordBits-1:0] col_inc;

  assign pop_o             = !q_empty_i && (!out_valid_q || out_o.ready);
  assign out_o.valid         = out_valid_q;
  assign out_o.write_address = out_addr_q;
  assign out_o.write_pixel   = out_pixel_q;
  assign out_o.last          = out_last_q;

  always_comb begin
    in_win = (src_row_q >= row_start_q)
          && (({1'b0, src_row_q} < row_lim_q) || (row_lim_q == '0))
          && (src_col_q >= col_start_q)
          && (({1'b0, src_col_q} < col_lim_q) || (col_lim_q == '0));
    row_done = ((CoordBits+1)'(src_col_q) + (CoordBits+1)'(1)) == col_lim_q;
    fin      = row_done && (((CoordBits+1)'(src_row_q) + (CoordBits+1)'(1)) == row_lim_q);
    emit     = pop_o && (cmd_i.kind == KindPixel) && busy_q && in_win;

    busy_d     = busy_q;
    src_row_d  = src_row_q;
    src_col_d  = src_col_q;
    row_base_d = row_base_q;
    col_addr_d = col_addr_q;
    col_inc    = src_col_q + CoordBits'(1);

    if (pop_o) begin
      unique case (cmd_i.kind)
        KindStart: begin
          busy_d     = cmd_i.ok;
          src_row_d  = '0;
          src_col_d  = '0;
          row_base_d = cmd_i.addr;
          col_addr_d = cmd_i.addr;
        end
        KindPixel: begin
          if (busy_q) begin
            if (in_win) begin
              col_addr_d = mx_q ? col_addr_q - AddrW'(1) : col_addr_q + AddrW'(1);
              if (row_done) begin
                row_base_d = my_q ? row_base_q - AddrW'(ScreenWidth)
                                  : row_base_q + AddrW'(ScreenWidth);
                col_addr_d = row_base_d;
              end
              if (fin) busy_d = 1'b0;
            end
            if (16'(col_inc) >= 16'(stride_q)) begin
              src_col_d = '0;
              src_row_d = src_row_q + CoordBits'(1);
            end else begin
              src_col_d = col_inc;
            end
          end
        end
        default: ;
      endcase
    end

    out_valid_d = emit || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_row_q  <= src_row_d;
    src_col_q  <= src_col_d;
    row_base_q <= row_base_d;
    col_addr_q <= col_addr_d;
    if (pop_o && cmd_i.kind == KindStart && cmd_i.ok) begin
      row_start_q <= cmd_i.row_start;
      col_start_q <= cmd_i.col_start;
      row_lim_q   <= cmd_i.row_lim;
      col_lim_q   <= cmd_i.col_lim;
      stride_q    <= cmd_i.stride;
      mx_q        <= cmd_i.mirror_x;
      my_q        <= cmd_i.mirror_y;
    end
    if (emit) begin
      out_addr_q  <= col_addr_q;
      out_pixel_q <= cmd_i.pixel;
      out_last_q  <= fin;
    end
  end

endmodule

// ===== src/clipped_flipped_sprite_blit_core.sv =====
// Top level of the clipped, flipped sprite blit: clip registers, front, queue and back.
// Takes one item per cycle and gives one framebuffer write per cycle when both sides
// keep up. A start item is resolved by a three-stage front (edge sums, clip amounts,
// stride cut and mirror corner) whose output stage forms the start address multiply,
// and queued; the back steps the source cursor and the wrapping write address for each
// pixel item and holds the write in an output register. A pixel item passes the front
// registers and the queue before its write is valid. The queue (QUEUE_DEPTH entries)
// lets the front keep accepting while the write side stalls; input ready drops only
// when the queue and front are full. There is no clearing pass after reset.
module clipped_flipped_sprite_blit_core import cfsb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  cfsb_in_if.sink     in_i,
  cfsb_out_if.source  out_o
);

  cfg_t    cfg_q;
  logic    q_push, q_pop;
  cmd_t    q_wdata, q_rdata;
  q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_left   <= 9'd0;
      cfg_q.clip_top    <= 8'd0;
      cfg_q.clip_right  <= 9'd320;
      cfg_q.clip_bottom <= 8'd200;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegClipLeft:   cfg_q.clip_left   <= cfg_data_i;
        RegClipTop:    cfg_q.clip_top    <= cfg_data_i[7:0];
        RegClipRight:  cfg_q.clip_right  <= cfg_data_i;
        RegClipBottom: cfg_q.clip_bottom <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  cfsb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .q_full_i    (q_stat.full),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  cfsb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  cfsb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_stat.empty),
    .cmd_i     (q_rdata),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

  a_queue_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.empty && q_stat.full))
    else $error("queue both empty and full");

  a_ready_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q_stat.full)
    else $error("input stalled with room in queue");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!q_stat.empty && (!out_o.valid || out_o.ready)))
    else $error("queue popped without room for a write");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !q_pop) |=> $stable(q_stat.full) || q_pop || $past(q_pop))
    else $error("queue overfilled");

endmodule

// ===== tb/clipped_flipped_sprite_blit_core_test.sv =====
// Self-checking testbench for the clipped, flipped sprite blit core.
module clipped_flipped_sprite_blit_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cfsb_pkg::*;

  typedef struct {
    kind_e              kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [9:0]         extent_w;
    logic [9:0]         extent_h;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_x_reloaded;
    logic [9:0]         row_stride;
    logic               mirror_x;
    logic               mirror_y;
    logic [7:0]         pixel;
  } blit_item_t;

  typedef struct {
    logic [15:0] address;
    logic [7:0]  pixel;
    logic        last;
  } fb_write_t;

  class blit_scoreboard;
    fb_write_t   pending_writes[$];
    int          errors;
    logic [8:0]  clip_left, clip_right;
    logic [7:0]  clip_top, clip_bottom;
    bit          busy;
    logic [9:0]  win_row0, win_col0, win_rows, win_cols, stride, src_row, src_col;
    logic [15:0] row_addr, col_addr;
    bit          flip_x, flip_y;

    function new();
      errors = 0;
      clip_left = 0;
      clip_top = 0;
      clip_right = 320;
      clip_bottom = 200;
      busy = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [8:0] v);
      case (idx)
        RegClipLeft:   clip_left = v;
        RegClipTop:    clip_top = v[7:0];
        RegClipRight:  clip_right = v;
        RegClipBottom: clip_bottom = v[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    // clip against the dirty rectangle and pick the source window
    function void resolve_start(blit_item_t it);
      int px, py, ox, oy, oxr, ew, eh, sw;
      int cl, ct, cr, cb;
      int top, bottom, left, right, h, w, rs, cs, dx, dy, c, cols;
      logic [31:0] lin;
      px = it.pos_x;
      py = it.pos_y;
      ox = it.offset_x;
      oy = it.offset_y;
      oxr = it.offset_x_reloaded;
      ew = it.extent_w;
      eh = it.extent_h;
      sw = it.row_stride;
      cl = clip_left;
      ct = clip_top;
      cr = clip_right;
      cb = clip_bottom;
      top = py + oy;
      bottom = top + eh;
      right = px + ew + ox;
      left = px + oxr;
      h = eh;
      w = ew;
      rs = 0;
      cs = 0;
      dx = left;
      dy = top;
      busy = 0;
      if (top < ct) begin
        c = ct - top;
        h -= c;
        if (!it.mirror_y) rs += c;
        dy = ct;
      end
      if (bottom >= cb) begin
        c = bottom - cb;
        h -= c;
        if (it.mirror_y) rs += c;
      end
      if (left < cl) begin
        c = cl - left;
        w -= c;
        if (!it.mirror_x) cs += c;
        dx = cl;
      end
      if (right >= cr) begin
        c = right - cr;
        w -= c;
        if (it.mirror_x) cs += c;
      end
      if (h <= 0 || w <= 0) return;
      if (cs >= sw) return;
      cols = w;
      if (cs + cols > sw) cols = sw - cs;
      if (it.mirror_y) dy += h - 1;
      if (it.mirror_x) dx += w - 1;
      lin = dy * 320 + dx;
      win_row0 = rs[9:0];
      win_col0 = cs[9:0];
      win_rows = h[9:0];
      win_cols = cols[9:0];
      stride = it.row_stride;
      src_row = 0;
      src_col = 0;
      row_addr = lin[15:0];
      col_addr = lin[15:0];
      flip_x = it.mirror_x;
      flip_y = it.mirror_y;
      busy = 1;
    endfunction

    function void step_pixel(logic [7:0] pix);
      int row_end, col_end;
      bit in_win, row_done, fin;
      fb_write_t wr;
      if (!busy) return;
      row_end = win_row0 + win_rows - 1;
      col_end = win_col0 + win_cols - 1;
      in_win = src_row >= win_row0 && src_row <= row_end &&
               src_col >= win_col0 && src_col <= col_end;
      if (in_win) begin
        row_done = src_col == col_end;
        fin = row_done && src_row == row_end;
        wr.address = col_addr;
        wr.pixel = pix;
        wr.last = fin;
        pending_writes.push_back(wr);
        col_addr = flip_x ? col_addr - 16'd1 : col_addr + 16'd1;
        if (row_done) begin
          row_addr = flip_y ? row_addr - 16'(ScreenWidth) : row_addr + 16'(ScreenWidth);
          col_addr = row_addr;
        end
        if (fin) busy = 0;
      end
      src_col = src_col + 10'd1;
      if (src_col >= stride) begin
        src_col = 0;
        src_row = src_row + 10'd1;
      end
    endfunction

    function void note_input(blit_item_t it);
      if (it.kind == KindStart) resolve_start(it);
      else step_pixel(it.pixel);
    endfunction

    function void check_write(fb_write_t got);
      fb_write_t want;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: address %h pixel %h last %b",
                 $time, got.address, got.pixel, got.last);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      if (got.address !== want.address) begin
        $display("%0t: write_address mismatch: expected %h actual %h",
                 $time, want.address, got.address);
        errors++;
      end
      if (got.pixel !== want.pixel) begin
        $display("%0t: write_pixel mismatch: expected %h actual %h",
                 $time, want.pixel, got.pixel);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [8:0] cfg_data_i;

  cfsb_in_if  in_bus ();
  cfsb_out_if out_bus ();

  clipped_flipped_sprite_blit_core uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  blit_scoreboard board = new();
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int live_items = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : write_side
    fb_write_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.address = out_bus.write_address;
      got.pixel = out_bus.write_pixel;
      got.last = out_bus.last;
      board.check_write(got);
    end
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic blit_item_t pixel_item();
    blit_item_t s;
    s.kind = KindPixel;
    s.pos_x = 16'($urandom);
    s.pos_y = 16'($urandom);
    s.extent_w = 10'($urandom);
    s.extent_h = 10'($urandom);
    s.offset_x = 16'($urandom);
    s.offset_y = 16'($urandom);
    s.offset_x_reloaded = 16'($urandom);
    s.row_stride = 10'($urandom);
    s.mirror_x = 1'($urandom);
    s.mirror_y = 1'($urandom);
    s.pixel = 8'($urandom);
    return s;
  endfunction

  function automatic blit_item_t random_start();
    blit_item_t s;
    s = pixel_item();
    s.kind = KindStart;
    if (s.extent_w == 0) s.extent_w = 1;
    if (s.extent_h == 0) s.extent_h = 1;
    if (s.row_stride == 0) s.row_stride = 1;
    return s;
  endfunction

  function automatic blit_item_t make_start(int x, int y, int ew, int eh, int ox, int oy,
                                            int oxr, int sw, bit fx, bit fy);
    blit_item_t s;
    s = pixel_item();
    s.kind = KindStart;
    s.pos_x = 16'(x);
    s.pos_y = 16'(y);
    s.extent_w = 10'(ew);
    s.extent_h = 10'(eh);
    s.offset_x = 16'(ox);
    s.offset_y = 16'(oy);
    s.offset_x_reloaded = 16'(oxr);
    s.row_stride = 10'(sw);
    s.mirror_x = fx;
    s.mirror_y = fy;
    return s;
  endfunction

  // small sprite placed around the current dirty rectangle
  function automatic blit_item_t aimed_start();
    int ew, eh, ox, oy, oxr, lo, hi, tx, ty;
    ew = $urandom_range(8, 1);
    eh = $urandom_range(6, 1);
    ox = int'($urandom_range(6)) - 3;
    oy = int'($urandom_range(6)) - 3;
    oxr = $urandom_range(1) ? ox : ox + int'($urandom_range(4)) - 2;
    lo = int'(board.clip_left) - ew - 2;
    hi = ((board.clip_right > board.clip_left) ? board.clip_right : board.clip_left) + 2;
    tx = lo + int'($urandom_range(hi - lo));
    lo = int'(board.clip_top) - eh - 2;
    hi = ((board.clip_bottom > board.clip_top) ? board.clip_bottom : board.clip_top) + 2;
    ty = lo + int'($urandom_range(hi - lo));
    return make_start(tx - oxr, ty - oy, ew, eh, ox, oy, oxr, $urandom_range(ew + 3, 1),
                      $urandom_range(1), $urandom_range(1));
  endfunction

  task automatic send(input blit_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.kind <= it.kind;
    in_bus.pos_x <= it.pos_x;
    in_bus.pos_y <= it.pos_y;
    in_bus.extent_w <= it.extent_w;
    in_bus.extent_h <= it.extent_h;
    in_bus.offset_x <= it.offset_x;
    in_bus.offset_y <= it.offset_y;
    in_bus.offset_x_reloaded <= it.offset_x_reloaded;
    in_bus.row_stride <= it.row_stride;
    in_bus.mirror_x <= it.mirror_x;
    in_bus.mirror_y <= it.mirror_y;
    in_bus.pixel <= it.pixel;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (it.kind == KindStart || board.busy) live_items++;
    board.note_input(it);
  endtask

  // start item, then pixel bytes until the blit ends or the cap is hit
  task automatic run_blit(input blit_item_t s, input int max_px);
    int n;
    n = 0;
    send(s);
    while (board.busy && n < max_px) begin
      send(pixel_item());
      n++;
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic program_clip(input logic [8:0] l, t, r, b);
    reg_idx_e   order[4];
    logic [8:0] v[4];
    order = '{RegClipLeft, RegClipTop, RegClipRight, RegClipBottom};
    v = '{l, t, r, b};
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_idx_i <= order[i];
      cfg_data_i <= v[i];
      @(posedge clk_i);
      board.set_reg(order[i], v[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  initial begin : main
    int cl, ct, cr, cb, mark, pick;
    in_bus.valid = 1'b0;
    in_bus.kind = KindStart;
    in_bus.pos_x = '0;
    in_bus.pos_y = '0;
    in_bus.extent_w = '0;
    in_bus.extent_h = '0;
    in_bus.offset_x = '0;
    in_bus.offset_y = '0;
    in_bus.offset_x_reloaded = '0;
    in_bus.row_stride = '0;
    in_bus.mirror_x = 1'b0;
    in_bus.mirror_y = 1'b0;
    in_bus.pixel = '0;
    out_bus.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegClipLeft;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_clip(0, 0, 320, 200);
    run_blit(make_start(10, 10, 2, 2, 0, 0, 0, 2, 0, 0), 8);
    run_blit(make_start(40, 20, 3, 2, 0, 0, 0, 3, 1, 1), 8);
    send(pixel_item());                                         // idle pixel
    run_blit(make_start(-1, -1, 2, 2, 0, 0, 0, 2, 1, 0), 8);     // top/left clip
    run_blit(make_start(318, 198, 2, 2, 0, 0, 0, 2, 0, 1), 8);   // bottom/right edge
    run_blit(make_start(400, 10, 2, 2, 0, 0, 0, 2, 0, 0), 1);    // fully clipped
    run_blit(make_start(100, 100, 4, 1, 2, -1, 1, 2, 0, 0), 8);  // window past stride
    run_blit(make_start(50, 50, 3, 3, 0, 0, 0, 3, 0, 0), 2);     // abandoned
    run_blit(make_start(-32768, 32767, 1023, 1023, 32767, -32768, 32767, 1023, 1, 1), 2);
    run_blit(make_start(32767, -32768, 1023, 1, -32768, 32767, -32768, 1023, 0, 0), 2);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin cl = 0; ct = 0; cr = 320; cb = 200; end
        1: begin cl = 0; ct = 0; cr = 0; cb = 0; end
        2: begin cl = 320; ct = 200; cr = 320; cb = 200; end
        3: begin
          cl = $urandom_range(300);
          cr = cl + $urandom_range(20, 1);
          ct = $urandom_range(190);
          cb = ct + $urandom_range(10, 1);
        end
        4: begin
          cl = $urandom_range(320);
          cr = $urandom_range(320);
          ct = $urandom_range(200);
          cb = $urandom_range(200);
        end
        default: begin cl = 7; ct = 3; cr = 313; cb = 197; end
      endcase
      program_clip(9'(cl), 9'(ct), 9'(cr), 9'(cb));
      case (p / 2)
        0: begin gap_pct = 37; stall_pct = 51; end
        1: begin gap_pct = 51; stall_pct = 37; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      if (p == 0) hold_left = 80;
      mark = live_items;
      while (live_items - mark < 85) begin
        pick = $urandom_range(99);
        if (pick < 75) run_blit(aimed_start(), ($urandom_range(7) == 0) ?
                                int'($urandom_range(3)) : 300);
        else if (pick < 90) run_blit(random_start(), $urandom_range(6));
        else send(pixel_item());
      end
    end

    drain();
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
